FILE: src/scba_pkg.sv
package scba_pkg;

   localparam int NUM_CLASSES = 7;
   localparam int NODES_PER_CLASS = 8;
   localparam int SLOTS_PER_NODE = 128;
   localparam int HEADER_BYTES = 8;
   localparam int MIN_SIZE = 8;
   localparam int MAX_SIZE = 512;
   localparam int WORD_BITS = 64;
   localparam int WORDS_PER_NODE = (SLOTS_PER_NODE + WORD_BITS - 1) / WORD_BITS;
   localparam int WORDS_PER_CLASS = NODES_PER_CLASS * WORDS_PER_NODE;
   localparam int TOTAL_WORDS = NUM_CLASSES * WORDS_PER_CLASS;
   localparam int ADDR_W = $clog2(TOTAL_WORDS);
   localparam int IDX_W = $clog2(WORDS_PER_CLASS);
   localparam int BIT_W = $clog2(WORD_BITS);
   localparam int TOTAL_W = 13;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE = 1'b1;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } map_rd_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [WORD_BITS-1:0] data;
   } map_wr_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] index;
   } zero_find_type;

   // Smallest class whose size holds the total; callers check the upper bound.
   function automatic logic [2:0] size_class(logic [TOTAL_W-1:0] total);
      logic [2:0] c;
      c = 3'(NUM_CLASSES - 1);
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (total <= TOTAL_W'(MIN_SIZE << i)) c = 3'(i);
      end
      return c;
   endfunction

   // Lowest clear bit of one usage word.
   function automatic zero_find_type lowest_zero(logic [WORD_BITS-1:0] w);
      zero_find_type r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r.found = 1'b1;
            r.index = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: src/scba_usage_store.sv
module scba_usage_store import scba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  map_rd_type           rd,
   input  map_wr_type           wr,
   output logic [WORD_BITS-1:0] rd_data
);

   // One word per class, node and half-node. A word never written reads as zero.
   logic [WORD_BITS-1:0]   mem [TOTAL_WORDS];
   logic [TOTAL_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0]   data_ff;
   logic                   hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      if (rd.en) data_ff <= mem[rd.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr.en) valid_ff[wr.addr] <= 1'b1;
         if (rd.en) hit_ff <= valid_ff[rd.addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

FILE: src/size_class_bitmap_slot_allocator_unit.sv
// Slab allocator over seven size classes (8 to 512 bytes). An allocate request
// adds an 8-byte header to its byte count, rounds up to a power of two and
// scans that class's eight nodes in order, taking the lowest free slot of the
// first node with room; it returns class, node, slot and the byte offset of
// the slot within its node. A request whose size rounds above 512 bytes gets
// status too large, and a class with every slot taken gets status out of space.
// A free request clears the slot it names; a class code of 7 is ignored. The
// usage maps live in a memory of 112 words of 64 bits, two words per node,
// read one word per cycle and searched by one lowest-zero encoder.
// An allocation reads the words of its class in order until one has a clear
// bit or the last word is searched, and the block stays busy until then. A
// free reads the word that holds its slot and writes it back. The result sits
// in an output register, so a new request is taken while the previous result
// still waits; the block only holds its last step when that register is still
// full. No clearing pass is needed after reset.
module size_class_bitmap_slot_allocator_unit import scba_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [11:0] req_request_bytes,
   input  logic [2:0]  req_free_class,
   input  logic [2:0]  req_free_node,
   input  logic [6:0]  req_free_slot,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_granted_class,
   output logic [2:0]  rsp_granted_node,
   output logic [6:0]  rsp_granted_slot,
   output logic [15:0] rsp_byte_offset
);

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FREE   = 2'd2;
   localparam logic [1:0] S_REJECT = 2'd3;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WORDS_PER_CLASS - 1);

   logic [1:0]       state_ff, state_in;
   logic [2:0]       cls_ff, cls_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             free_ok_ff, free_ok_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [2:0]  rsp_class_ff, rsp_class_in;
   logic [2:0]  rsp_node_ff, rsp_node_in;
   logic [6:0]  rsp_slot_ff, rsp_slot_in;
   logic [15:0] rsp_offset_ff, rsp_offset_in;

   map_rd_type           map_rd;
   map_wr_type           map_wr;
   logic [WORD_BITS-1:0] map_data;

   logic [TOTAL_W-1:0] req_total;
   logic               req_too_large;
   logic [2:0]         req_cls;
   logic               out_free;
   zero_find_type      zf;
   logic [6:0]         scan_slot;
   logic [15:0]        scan_offset;

   scba_usage_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (map_rd),
      .wr      (map_wr),
      .rd_data (map_data)
   );

   // Size class of the incoming request, header included.
   assign req_total     = TOTAL_W'(req_request_bytes) + TOTAL_W'(HEADER_BYTES);
   assign req_too_large = req_total > TOTAL_W'(MAX_SIZE);
   assign req_cls       = size_class(req_total);

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The word being examined arrived from the memory this cycle.
   assign zf          = lowest_zero(map_data);
   assign scan_slot   = {idx_ff[0], zf.index};
   assign scan_offset = 16'(scan_slot) << ({1'b0, cls_ff} + 4'd3);

   always_comb begin
      state_in      = state_ff;
      cls_in        = cls_ff;
      idx_in        = idx_ff;
      bit_in        = bit_ff;
      free_ok_in    = free_ok_ff;
      map_rd        = '0;
      map_wr        = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_offset_in = rsp_offset_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_FREE) begin
                  // Read the word holding the slot; the write-back follows.
                  cls_in      = req_free_class;
                  idx_in      = {req_free_node, req_free_slot[6]};
                  bit_in      = req_free_slot[5:0];
                  free_ok_in  = req_free_class < 3'(NUM_CLASSES);
                  map_rd.en   = free_ok_in;
                  map_rd.addr = {req_free_class, req_free_node, req_free_slot[6]};
                  state_in    = S_FREE;
               end else if (req_too_large) begin
                  state_in = S_REJECT;
               end else begin
                  cls_in      = req_cls;
                  idx_in      = '0;
                  map_rd.en   = 1'b1;
                  map_rd.addr = {req_cls, IDX_W'(0)};
                  state_in    = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (zf.found) begin
               if (out_free) begin
                  map_wr.en     = 1'b1;
                  map_wr.addr   = {cls_ff, idx_ff};
                  map_wr.data   = map_data | (WORD_BITS'(1) << zf.index);
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_class_in  = cls_ff;
                  rsp_node_in   = idx_ff[IDX_W-1:1];
                  rsp_slot_in   = scan_slot;
                  rsp_offset_in = scan_offset;
                  state_in      = S_IDLE;
               end
            end else if (idx_ff == IDX_LAST) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NO_SPACE;
                  rsp_class_in  = cls_ff;
                  rsp_node_in   = '0;
                  rsp_slot_in   = '0;
                  rsp_offset_in = '0;
                  state_in      = S_IDLE;
               end
            end else begin
               // Fetch the next word; its data is searched next cycle.
               idx_in      = idx_ff + IDX_W'(1);
               map_rd.en   = 1'b1;
               map_rd.addr = {cls_ff, idx_in};
            end
         end

         S_FREE: begin
            if (out_free) begin
               map_wr.en     = free_ok_ff;
               map_wr.addr   = {cls_ff, idx_ff};
               map_wr.data   = map_data & ~(WORD_BITS'(1) << bit_ff);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_class_in  = '0;
               rsp_node_in   = '0;
               rsp_slot_in   = '0;
               rsp_offset_in = '0;
               state_in      = S_IDLE;
            end
         end

         S_REJECT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_TOO_LARGE;
               rsp_class_in  = '0;
               rsp_node_in   = '0;
               rsp_slot_in   = '0;
               rsp_offset_in = '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff        <= cls_in;
      idx_ff        <= idx_in;
      bit_ff        <= bit_in;
      free_ok_ff    <= free_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_class = rsp_class_ff;
   assign rsp_granted_node  = rsp_node_ff;
   assign rsp_granted_slot  = rsp_slot_ff;
   assign rsp_byte_offset   = rsp_offset_ff;

   // The usage map is only written while a scan or a free finishes.
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      map_wr.en |-> (state_ff == S_SCAN || state_ff == S_FREE))
      else $error("usage map written outside a scan or free");

   // Every map write completes a request and leaves a result behind.
   a_write_result: assert property (@(posedge clock) disable iff (reset)
      map_wr.en |=> rsp_valid_ff)
      else $error("map write without a result");

   // A scan always starts at the first word of its class.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && $past(state_ff) == S_IDLE) |-> idx_ff == '0)
      else $error("scan did not start at the first word");

   // Granted offsets are multiples of the smallest class size.
   a_offset_align: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_OK) |-> rsp_offset_ff[2:0] == 3'd0)
      else $error("granted offset not aligned");

   // The block never reads the map while idle without taking a request.
   a_read_idle: assert property (@(posedge clock) disable iff (reset)
      (map_rd.en && state_ff == S_IDLE) |-> req_valid)
      else $error("map read while idle without a request");

endmodule

FILE: tb/slab_grant_checker.sv
module slab_grant_checker import scba_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [11:0] req_request_bytes,
   input  logic [2:0]  req_free_class,
   input  logic [2:0]  req_free_node,
   input  logic [6:0]  req_free_slot,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [2:0]  rsp_granted_class,
   input  logic [2:0]  rsp_granted_node,
   input  logic [6:0]  rsp_granted_slot,
   input  logic [15:0] rsp_byte_offset,

   output int          mismatch_count
);

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  cls;
      logic [2:0]  node;
      logic [6:0]  slot;
      logic [15:0] offset;
   } grant_type;

   // Usage maps of every node of every class, one bit per slot.
   logic [SLOTS_PER_NODE-1:0] slot_map [NUM_CLASSES][NODES_PER_CLASS];
   grant_type expected_grants[$];

   task automatic report(input string msg);
      if (mismatch_count < 100) $display("%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Works out the grant for one request and updates the usage maps.
   function automatic grant_type predict_grant(input logic kind, input logic [11:0] bytes,
                                               input logic [2:0] fcls, input logic [2:0] fnode,
                                               input logic [6:0] fslot);
      grant_type g;
      logic [12:0] total;
      int cls;
      bit found;
      g = '0;
      if (kind == KIND_FREE) begin
         if (fcls < NUM_CLASSES && fnode < NODES_PER_CLASS && fslot < SLOTS_PER_NODE)
            slot_map[fcls][fnode][fslot] = 1'b0;
         return g;
      end
      total = 13'(bytes) + 13'(HEADER_BYTES);
      if (total > MAX_SIZE) begin
         g.status = STATUS_TOO_LARGE;
         return g;
      end
      cls = 0;
      while ((MIN_SIZE << cls) < total) cls++;
      g.cls = 3'(cls);
      g.status = STATUS_NO_SPACE;
      found = 1'b0;
      for (int n = 0; n < NODES_PER_CLASS && !found; n++) begin
         for (int s = 0; s < SLOTS_PER_NODE && !found; s++) begin
            if (!slot_map[cls][n][s]) begin
               slot_map[cls][n][s] = 1'b1;
               found = 1'b1;
               g.status = STATUS_OK;
               g.node = 3'(n);
               g.slot = 7'(s);
               g.offset = 16'(s * (MIN_SIZE << cls));
            end
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type g;
      if (reset) begin
         foreach (slot_map[c, n]) slot_map[c][n] = '0;
         expected_grants.delete();
      end else begin
         // Results never leave in the cycle that took their request, so compare first.
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               report("result arrived with no request outstanding");
            end else begin
               g = expected_grants.pop_front();
               if (rsp_status !== g.status)
                  report($sformatf("status: expected %0d, got %0d", g.status, rsp_status));
               if (rsp_granted_class !== g.cls)
                  report($sformatf("class: expected %0d, got %0d", g.cls, rsp_granted_class));
               if (rsp_granted_node !== g.node)
                  report($sformatf("node: expected %0d, got %0d", g.node, rsp_granted_node));
               if (rsp_granted_slot !== g.slot)
                  report($sformatf("slot: expected %0d, got %0d", g.slot, rsp_granted_slot));
               if (rsp_byte_offset !== g.offset)
                  report($sformatf("offset: expected %0d, got %0d", g.offset, rsp_byte_offset));
            end
         end
         if (req_valid && req_ready)
            expected_grants.push_back(predict_grant(req_kind, req_request_bytes,
                                                    req_free_class, req_free_node,
                                                    req_free_slot));
      end
   end

endmodule

FILE: tb/size_class_bitmap_slot_allocator_unit_tb.sv
module size_class_bitmap_slot_allocator_unit_tb import scba_pkg::*; ();

   // The slowest correct run is roughly 1250 requests, each with the longest busy
   // time and the longest gaps on both sides, plus one long hold-off. The limit
   // leaves plenty of margin.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct {
      logic [2:0] cls;
      logic [2:0] node;
      logic [6:0] slot;
   } handle_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_ALLOC;
   logic [11:0] req_request_bytes = '0;
   logic [2:0]  req_free_class = '0;
   logic [2:0]  req_free_node = '0;
   logic [6:0]  req_free_slot = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_granted_class;
   logic [2:0]  rsp_granted_node;
   logic [6:0]  rsp_granted_slot;
   logic [15:0] rsp_byte_offset;

   int          mismatch_count;
   int          cycle_count = 0;

   // The kind of every accepted request, in order, until its result is taken.
   // Its size is the number of results still owed by the block.
   logic        issued_kinds[$];
   // Slots granted to us and not yet given back, so that frees name live slots.
   handle_type  live_handles[$];
   // Set by the request side to ask the result side for one long hold-off.
   bit          hold_off_request = 1'b0;
   // While set, neither side inserts idle cycles.
   bit          no_idle = 1'b0;

   size_class_bitmap_slot_allocator_unit i_dut (.*);

   slab_grant_checker i_checker (.*);

   always #10 clock = ~clock;

   // Guard against a hung block: a run that is still going here has failed.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Idle gaps are mostly absent or short, and now and then a long one.
   function automatic int idle_length();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // A random payload byte count that lands in the given size class once the
   // header is added.
   function automatic logic [11:0] bytes_for_class(input int cls);
      int lo;
      int hi;
      lo = (cls == 0) ? 0 : (MIN_SIZE << (cls - 1)) - HEADER_BYTES + 1;
      hi = (MIN_SIZE << cls) - HEADER_BYTES;
      return 12'($urandom_range(hi, lo));
   endfunction

   // Offers one request and returns right after the edge that accepted it.
   // Valid is left high, so a back-to-back request simply follows.
   task automatic offer(input logic kind, input logic [11:0] bytes, input logic [2:0] fcls,
                        input logic [2:0] fnode, input logic [6:0] fslot);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_request_bytes <= bytes;
      req_free_class <= fcls;
      req_free_node <= fnode;
      req_free_slot <= fslot;
      do @(posedge clock); while (!req_ready);
      issued_kinds.push_back(kind);
   endtask

   // An allocate request; the unused free fields carry random values.
   task automatic allocate(input logic [11:0] bytes);
      offer(KIND_ALLOC, bytes, 3'($urandom), 3'($urandom), 7'($urandom));
   endtask

   // A free request; the unused byte count carries a random value.
   task automatic offer_free(input logic [2:0] fcls, input logic [2:0] fnode,
                             input logic [6:0] fslot);
      offer(KIND_FREE, 12'($urandom), fcls, fnode, fslot);
   endtask

   task automatic pause_sender();
      int n;
      n = idle_length();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stops offering until every result owed by the block has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (issued_kinds.size() != 0) @(posedge clock);
   endtask

   // Result side: takes results with random stalls, records granted slots for
   // later frees, and serves the long hold-off when the request side asks.
   initial begin
      int stall_left;
      int n;
      logic done_kind;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready && issued_kinds.size() != 0) begin
            done_kind = issued_kinds.pop_front();
            if (done_kind == KIND_ALLOC && rsp_status == STATUS_OK)
               live_handles.push_back('{rsp_granted_class, rsp_granted_node,
                                        rsp_granted_slot});
         end
         if (hold_off_request) begin
            stall_left = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            n = idle_length();
            if (n == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               stall_left = n - 1;
            end
         end
      end
   end

   // Request side and verdict.
   initial begin
      int big_allocs;
      int r;
      int pick;
      handle_type h;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests, back to back: class boundaries on one or both sides of
      // each power of two, the largest payload that still fits, payloads that
      // are too large (including all ones), and the free corner cases.
      no_idle = 1'b1;
      allocate(12'd0);
      allocate(12'd1);
      allocate(12'd8);
      allocate(12'd9);
      allocate(12'd24);
      allocate(12'd25);
      allocate(12'd56);
      allocate(12'd120);
      allocate(12'd121);
      allocate(12'd248);
      allocate(12'd249);
      allocate(12'd504);
      allocate(12'd505);
      allocate(12'd2048);
      allocate(12'd4095);
      // Free a live slot, then the same slot again (double free).
      offer_free(3'd0, 3'd0, 7'd0);
      offer_free(3'd0, 3'd0, 7'd0);
      // A class code past the last class must be ignored.
      offer_free(3'd7, 3'd3, 7'd5);
      offer_free(3'd7, 3'd7, 7'd127);
      // Freeing a slot that was never granted leaves it free.
      offer_free(3'd6, 3'd7, 7'd127);
      // The freed slot must be handed out again before any higher one.
      allocate(12'd0);
      allocate(12'd0);
      no_idle = 1'b0;

      // Fill the 512-byte class completely so that its last node and slot,
      // the largest offset, and then out-of-space results are reached. A few
      // too-large and ignored free requests are mixed in. Partway through, the
      // result side holds off for a long stretch while requests keep coming,
      // so the block fills up and stalls its input.
      big_allocs = 2;
      for (int i = 0; big_allocs < 1040; i++) begin
         if (i == 250) hold_off_request = 1'b1;
         no_idle = ((i / 150) % 3 == 1);
         r = $urandom_range(99, 0);
         if (r < 4) begin
            allocate(12'($urandom_range(4095, 505)));
         end else if (r < 6) begin
            offer_free(3'd7, 3'($urandom), 7'($urandom));
         end else begin
            allocate(bytes_for_class(6));
            big_allocs++;
         end
         pause_sender();
      end
      no_idle = 1'b0;
      drain();

      // Mixed traffic: mostly frees of live slots and allocations of every
      // class, which punches holes into the full class and refills them, with
      // too-large requests, random frees and random byte counts as noise.
      for (int i = 0; i < 130; i++) begin
         no_idle = ((i / 40) % 3 == 2);
         r = $urandom_range(99, 0);
         if (r < 35 && live_handles.size() > 0) begin
            pick = $urandom_range(live_handles.size() - 1, 0);
            h = live_handles[pick];
            live_handles.delete(pick);
            offer_free(h.cls, h.node, h.slot);
         end else if (r < 75) begin
            allocate(bytes_for_class($urandom_range(6, 0)));
         end else if (r < 85) begin
            allocate(12'($urandom_range(4095, 505)));
         end else if (r < 95) begin
            offer_free(3'($urandom), 3'($urandom), 7'($urandom));
         end else begin
            allocate(12'($urandom));
         end
         if (i == 65) drain();
         else pause_sender();
      end

      // Wait for every owed result, then a little longer to catch strays.
      no_idle = 1'b0;
      drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/scba_pkg.sv
src/scba_usage_store.sv
src/size_class_bitmap_slot_allocator_unit.sv
tb/slab_grant_checker.sv
tb/size_class_bitmap_slot_allocator_unit_tb.sv
